// File: design/scpd_pkg.sv
// ----------------------------------------------------------------------------
// scpd_pkg
// Shared types, constants and the sine table of the sliding correlator.
// ----------------------------------------------------------------------------
package scpd_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int PROD_W       = SAMPLE_BITS + 1;
    localparam int MAG_W        = 52;
    localparam int PHASE_W      = 16;
    localparam int WIN_LEN_W    = 11;
    localparam int SLOPE_W      = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_CNT = 2'd2;

    localparam logic [PHASE_W-1:0]   RST_PHASE_INC = 16'd6554;
    localparam logic [WIN_LEN_W-1:0] RST_WIN_LEN   = 11'd170;
    localparam logic [SLOPE_W-1:0]   RST_SLOPE_CNT = 4'd3;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [SLOPE_W-1:0] SLOPE_SAT    = 4'd15;
    localparam logic [MAG_W-1:0]   MAG_MAX      = {MAG_W{1'b1}};

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic signed [SAMPLE_BITS-1:0] sample_q;
    } t_in_item;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude_squared;
        logic             peak_found;
    } t_out_item;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase_inc;
        logic [WIN_LEN_W-1:0] win_len;
    } t_front_cfg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SUM,
        BK_SQUARE,
        BK_DETECT
    } t_back_state;

    typedef logic signed [SAMPLE_BITS-1:0] t_sine_rom [SINE_ENTRIES];

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] f;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            f    = ((64'(k) << 32) / SINE_ENTRIES) & 64'hFFFF_FFFF;
            quad = f >> 30;
            r    = f & (Q30_ONE - 64'd1);
            if (quad[0]) begin
                r = Q30_ONE - r;
            end
            x  = (r * HALF_PI_Q30) >> 30;
            x2 = (x * x) >> 30;
            t  = Q30_ONE - ((x2 * Q30_ONE) >> 30) / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            s  = (s + (64'd1 << 14)) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            if (quad >= 64'd2) begin
                rom[k] = -$signed(s[SAMPLE_BITS-1:0]);
            end else begin
                rom[k] = $signed(s[SAMPLE_BITS-1:0]);
            end
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// File: design/scpd_front.sv
// ----------------------------------------------------------------------------
// scpd_front
// Accepts samples, steps the oscillator and the window position, and forms
// the two scaled oscillator products that are queued for the back end.
// ----------------------------------------------------------------------------
module scpd_front #(
    parameter int MAX_WINDOW = 1024,
    parameter int ADDR_W     = 10,
    parameter int QW         = 45
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scpd_pkg::t_front_cfg i_cfg,
    input  logic                i_clear,
    input  logic                i_in_valid,
    input  scpd_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_push,
    output logic [QW-1:0]       o_push_data,
    input  logic                i_q_full
);
    import scpd_pkg::*;

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (LEN_W > WIN_LEN_W) ? LEN_W : WIN_LEN_W;

    logic                          r_stg_valid;
    logic signed [SAMPLE_BITS-1:0] r_stg_si;
    logic signed [SAMPLE_BITS-1:0] r_stg_sq;
    logic signed [SAMPLE_BITS-1:0] r_stg_cos;
    logic signed [SAMPLE_BITS-1:0] r_stg_sin;
    logic [ADDR_W-1:0]             r_stg_pos;
    logic                          r_stg_old;
    logic [ADDR_W-1:0]             r_pos;
    logic [PHASE_W-1:0]            r_phase;
    logic                          r_wrapped;

    logic [CMP_W-1:0]              len_cmp;
    logic [LEN_W-1:0]              eff_len;
    logic [LEN_W-1:0]              pos_inc;
    logic [ADDR_W-1:0]             n_pos;
    logic                          wrap;
    logic [PHASE_W-1:0]            use_phase;
    logic [PHASE_W-1:0]            cos_phase;
    logic [PHASE_W-1:0]            n_phase;
    logic                          accept;
    logic signed [2*SAMPLE_BITS-1:0] prod_i;
    logic signed [2*SAMPLE_BITS-1:0] prod_q;

    always_comb begin
        len_cmp = CMP_W'(i_cfg.win_len);
        if (len_cmp == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_cmp > CMP_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = len_cmp[LEN_W-1:0];
        end
        pos_inc = LEN_W'(r_pos) + LEN_W'(1);
        wrap    = (pos_inc >= eff_len);
        n_pos   = wrap ? '0 : pos_inc[ADDR_W-1:0];
        use_phase = (r_pos == '0) ? '0 : r_phase;
        cos_phase = use_phase + QUARTER_TURN;
        n_phase   = use_phase + i_cfg.phase_inc;
    end

    assign o_push     = r_stg_valid && !i_q_full;
    assign o_in_stall = r_stg_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_pos       <= '0;
            r_phase     <= '0;
            r_wrapped   <= 1'b0;
        end else begin
            if (accept) begin
                r_stg_valid <= 1'b1;
            end else if (o_push) begin
                r_stg_valid <= 1'b0;
            end
            if (i_clear) begin
                r_pos     <= '0;
                r_phase   <= '0;
                r_wrapped <= 1'b0;
            end else if (accept) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                if (wrap) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg_si  <= i_in_data.sample_i;
            r_stg_sq  <= i_in_data.sample_q;
            r_stg_cos <= SINE_ROM[cos_phase[PHASE_W-1 -: SINE_IDX_W]];
            r_stg_sin <= SINE_ROM[use_phase[PHASE_W-1 -: SINE_IDX_W]];
            r_stg_pos <= r_pos;
            r_stg_old <= r_wrapped;
        end
    end

    assign prod_i = r_stg_si * r_stg_cos;
    assign prod_q = r_stg_sq * r_stg_sin;

    assign o_push_data = {prod_i[2*SAMPLE_BITS-1 -: PROD_W],
                          prod_q[2*SAMPLE_BITS-1 -: PROD_W],
                          r_stg_pos, r_stg_old};

endmodule

// File: design/scpd_fifo.sv
// ----------------------------------------------------------------------------
// scpd_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module scpd_fifo #(
    parameter int WIDTH = 45
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import scpd_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: design/scpd_back.sv
// ----------------------------------------------------------------------------
// scpd_back
// Keeps the product ring and the running sums, squares the sums, runs the
// slope peak detector and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module scpd_back #(
    parameter int MAX_WINDOW = 1024,
    parameter int ADDR_W     = 10,
    parameter int QW         = 45
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic [scpd_pkg::SLOPE_W-1:0] i_slope_cnt,
    input  logic [QW-1:0]             i_q_data,
    input  logic                      i_q_empty,
    output logic                      o_pop,
    output logic                      o_out_valid,
    output scpd_pkg::t_out_item       o_out_data,
    input  logic                      i_out_stall
);
    import scpd_pkg::*;

    localparam int SUM_W  = PROD_W + $clog2(MAX_WINDOW) + 1;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int WIDE_W = (SQ_W + 1 > MAG_W) ? SQ_W + 1 : MAG_W;

    t_back_state              r_state;
    t_back_state              n_state;
    logic signed [SUM_W-1:0]  r_sum_i;
    logic signed [SUM_W-1:0]  r_sum_q;
    logic signed [SUM_W-1:0]  n_sum_i;
    logic signed [SUM_W-1:0]  n_sum_q;
    logic [MAG_W-1:0]         r_prev_mag;
    logic [SLOPE_W-1:0]       r_rise;
    logic [SLOPE_W-1:0]       r_fall;
    logic [SLOPE_W-1:0]       n_rise;
    logic [SLOPE_W-1:0]       n_fall;
    logic                     r_out_valid;
    t_out_item                r_out_data;

    logic signed [PROD_W-1:0] r_prod_i;
    logic signed [PROD_W-1:0] r_prod_q;
    logic [ADDR_W-1:0]        r_pos;
    logic                     r_old;
    logic [2*PROD_W-1:0]      r_ring_rd;
    logic signed [SQ_W-1:0]   r_sq_i;
    logic signed [SQ_W-1:0]   r_sq_q;
    logic [2*PROD_W-1:0]      ring_mem [MAX_WINDOW];

    logic                     ring_we;
    logic                     do_sum;
    logic                     do_square;
    logic                     load_out;
    logic                     out_free;
    logic [PROD_W-1:0]        old_i;
    logic [PROD_W-1:0]        old_q;
    logic [WIDE_W-1:0]        mag_wide;
    logic [MAG_W-1:0]         mag;
    logic [SLOPE_W-1:0]       need;
    logic [SLOPE_W-1:0]       fall_inc;
    logic                     peak;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = BK_SUM;
                end
            end
            BK_SUM: begin
                n_state = BK_SQUARE;
            end
            BK_SQUARE: begin
                n_state = BK_DETECT;
            end
            BK_DETECT: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        ring_we   = 1'b0;
        do_sum    = 1'b0;
        do_square = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop = !i_q_empty;
            end
            BK_SUM: begin
                ring_we = 1'b1;
                do_sum  = 1'b1;
            end
            BK_SQUARE: begin
                do_square = 1'b1;
            end
            BK_DETECT: begin
                load_out = out_free;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        old_i   = r_old ? r_ring_rd[2*PROD_W-1 -: PROD_W] : '0;
        old_q   = r_old ? r_ring_rd[PROD_W-1:0] : '0;
        n_sum_i = r_sum_i - {{(SUM_W-PROD_W){old_i[PROD_W-1]}}, old_i}
                  + {{(SUM_W-PROD_W){r_prod_i[PROD_W-1]}}, r_prod_i};
        n_sum_q = r_sum_q - {{(SUM_W-PROD_W){old_q[PROD_W-1]}}, old_q}
                  + {{(SUM_W-PROD_W){r_prod_q[PROD_W-1]}}, r_prod_q};
    end

    always_comb begin
        mag_wide = WIDE_W'(r_sq_i[SQ_W-1:0]) + WIDE_W'(r_sq_q[SQ_W-1:0]);
        if (mag_wide > WIDE_W'(MAG_MAX)) begin
            mag = MAG_MAX;
        end else begin
            mag = mag_wide[MAG_W-1:0];
        end
        need     = (i_slope_cnt == '0) ? SLOPE_W'(1) : i_slope_cnt;
        fall_inc = (r_fall < SLOPE_SAT) ? r_fall + SLOPE_W'(1) : r_fall;
        peak     = 1'b0;
        n_rise   = '0;
        n_fall   = '0;
        if (mag > r_prev_mag) begin
            n_rise = (r_rise < SLOPE_SAT) ? r_rise + SLOPE_W'(1) : r_rise;
        end else if (mag < r_prev_mag) begin
            if (r_rise >= need) begin
                if (fall_inc >= need) begin
                    peak = 1'b1;
                end else begin
                    n_rise = r_rise;
                    n_fall = fall_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_sum_i     <= '0;
            r_sum_q     <= '0;
            r_prev_mag  <= '0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_clear) begin
                r_sum_i <= '0;
                r_sum_q <= '0;
            end else if (do_sum) begin
                r_sum_i <= n_sum_i;
                r_sum_q <= n_sum_q;
            end
            if (load_out) begin
                r_prev_mag  <= mag;
                r_rise      <= n_rise;
                r_fall      <= n_fall;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod_i <= i_q_data[QW-1 -: PROD_W];
            r_prod_q <= i_q_data[QW-PROD_W-1 -: PROD_W];
            r_pos    <= i_q_data[ADDR_W:1];
            r_old    <= i_q_data[0];
        end
        if (do_square) begin
            r_sq_i <= r_sum_i * r_sum_i;
            r_sq_q <= r_sum_q * r_sum_q;
        end
        if (load_out) begin
            r_out_data.magnitude_squared <= mag;
            r_out_data.peak_found        <= peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ring_rd <= ring_mem[i_q_data[ADDR_W:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_pos] <= {r_prod_i, r_prod_q};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/sliding_correlator_peak_detect.sv
// ----------------------------------------------------------------------------
// sliding_correlator_peak_detect
// Sliding-window oscillator correlator with a slope-based peak detector.
// ----------------------------------------------------------------------------
// Each input item carries one complex sample on i_in_data. The item is taken
// at a clock edge where i_in_valid is high and o_in_stall is low. Each item
// gives exactly one result item on o_out_data: the squared magnitude of the
// windowed I and Q sums and a peak flag. It is taken where o_out_valid is
// high and i_out_stall is low.
// The back end is a four-step sequencer (ring read, sum update, squaring,
// detection) and works on one item at a time: it takes the next item from
// the queue only after the last result is loaded. A two-entry queue and an
// input stage let the front keep taking items while the back end works.
// When the receiver stalls, the result item holds and the back end waits;
// the queue fills and then o_in_stall rises. Configuration is written
// through i_cfg_wr_en, i_cfg_index and i_cfg_data while the block is idle;
// the user must ensure this, the block does not. Writing the window length
// restarts the window. After a synchronous reset the registers hold their
// defaults and the window and sums are empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_correlator_peak_detect #(
    parameter int MAX_WINDOW = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [scpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    input  scpd_pkg::t_in_item                 i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output scpd_pkg::t_out_item                o_out_data,
    input  logic                               i_out_stall
);
    import scpd_pkg::*;

    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int QW     = 2 * PROD_W + ADDR_W + 1;

    logic [PHASE_W-1:0]   r_phase_inc;
    logic [WIN_LEN_W-1:0] r_win_len;
    logic [SLOPE_W-1:0]   r_slope_cnt;
    logic                 clear;
    t_front_cfg           front_cfg;
    logic                 push;
    logic [QW-1:0]        push_data;
    logic                 q_full;
    logic                 pop;
    logic [QW-1:0]        q_data;
    logic                 q_empty;

    assign clear = i_cfg_wr_en && (i_cfg_index == CFG_WIN_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= RST_PHASE_INC;
            r_win_len   <= RST_WIN_LEN;
            r_slope_cnt <= RST_SLOPE_CNT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PHASE_INC: begin
                    r_phase_inc <= i_cfg_data[PHASE_W-1:0];
                end
                CFG_WIN_LEN: begin
                    r_win_len <= i_cfg_data[WIN_LEN_W-1:0];
                end
                CFG_SLOPE_CNT: begin
                    r_slope_cnt <= i_cfg_data[SLOPE_W-1:0];
                end
                default: begin
                    r_slope_cnt <= r_slope_cnt;
                end
            endcase
        end
    end

    assign front_cfg.phase_inc = r_phase_inc;
    assign front_cfg.win_len   = r_win_len;

    scpd_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .ADDR_W     (ADDR_W),
        .QW         (QW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (front_cfg),
        .i_clear     (clear),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data),
        .i_q_full    (q_full)
    );

    scpd_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_data      (q_data),
        .o_empty     (q_empty)
    );

    scpd_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .ADDR_W     (ADDR_W),
        .QW         (QW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .i_slope_cnt (r_slope_cnt),
        .i_q_data    (q_data),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
